/* hdl/mcwd_pkg.sv */
// Shared types and constants for the multi-channel watchdog.
package mcwd_pkg;

    localparam int CHANNELS = 8;
    localparam int CNT_W    = $clog2(CHANNELS + 1);

    typedef enum logic [2:0] {
        OP_REGISTER = 3'd0,
        OP_KICK     = 3'd1,
        OP_START    = 3'd2,
        OP_PAUSE    = 3'd3,
        OP_STOP     = 3'd4,
        OP_TICK     = 3'd5
    } t_op;

    typedef struct packed {
        logic [2:0] operation;
        logic [2:0] watch_index;
    } t_item;

    typedef struct packed {
        logic [2:0] assigned_index;
        logic       accepted;
        logic       tripped;
        logic [7:0] missed_mask;
        logic       stopped_now;
        logic       watching_now;
    } t_result;

endpackage

/* hdl/mcwd_core.sv */
// Watchdog state registers and the combinational operation decode.
module mcwd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  mcwd_pkg::t_item  i_item,
    output mcwd_pkg::t_result o_res
);

    logic [mcwd_pkg::CHANNELS-1:0] r_alive, n_alive;
    logic [mcwd_pkg::CHANNELS-1:0] reg_set, slot_hot, kick_hot, missed;
    logic [mcwd_pkg::CNT_W-1:0]    r_total, n_total;
    logic                          r_watch, n_watch;
    logic                          r_halted, n_halted;
    logic                          kick_ok;
    logic [7:0]                    missed_low;

    // Per-channel decode: registered slots, next free slot, kick target.
    always_comb begin
        for (int i = 0; i < mcwd_pkg::CHANNELS; i++) begin
            reg_set[i]  = (mcwd_pkg::CNT_W'(i) < r_total);
            slot_hot[i] = (mcwd_pkg::CNT_W'(i) == r_total);
            kick_hot[i] = ({29'd0, i_item.watch_index} == 32'(i));
        end
    end

    assign kick_ok = ({29'd0, i_item.watch_index} < 32'(mcwd_pkg::CHANNELS));
    assign missed  = r_watch ? (reg_set & ~r_alive) : '0;

    // Only channels 0 to 7 are visible in the mask.
    for (genvar b = 0; b < 8; b++) begin : g_mask
        if (b < mcwd_pkg::CHANNELS) begin : g_on
            assign missed_low[b] = missed[b];
        end else begin : g_off
            assign missed_low[b] = 1'b0;
        end
    end

    always_comb begin
        n_alive  = r_alive;
        n_total  = r_total;
        n_watch  = r_watch;
        n_halted = r_halted;
        o_res    = '0;
        if (i_item.operation == mcwd_pkg::OP_STOP) begin
            n_halted       = 1'b1;
            o_res.accepted = 1'b1;
        end else if (!r_halted) begin
            case (i_item.operation)
                mcwd_pkg::OP_REGISTER: begin
                    if (r_total < mcwd_pkg::CNT_W'(mcwd_pkg::CHANNELS)) begin
                        o_res.assigned_index = 3'(r_total);
                        o_res.accepted       = 1'b1;
                        n_alive              = r_alive | slot_hot;
                        n_total              = r_total + 1'b1;
                    end
                end
                mcwd_pkg::OP_KICK: begin
                    if (kick_ok) begin
                        o_res.accepted = 1'b1;
                        n_alive        = r_alive | kick_hot;
                    end
                end
                mcwd_pkg::OP_START: begin
                    n_watch        = 1'b1;
                    o_res.accepted = 1'b1;
                end
                mcwd_pkg::OP_PAUSE: begin
                    n_watch        = 1'b0;
                    o_res.accepted = 1'b1;
                end
                mcwd_pkg::OP_TICK: begin
                    o_res.accepted = 1'b1;
                    n_alive        = '0;
                    if (|missed) begin
                        o_res.tripped     = 1'b1;
                        o_res.missed_mask = missed_low;
                        n_halted          = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        o_res.stopped_now  = n_halted;
        o_res.watching_now = n_watch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive  <= '0;
            r_total  <= '0;
            r_watch  <= 1'b0;
            r_halted <= 1'b0;
        end else if (i_fire) begin
            r_alive  <= n_alive;
            r_total  <= n_total;
            r_watch  <= n_watch;
            r_halted <= n_halted;
        end
    end

    // Stop is sticky until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halted state cleared without reset");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= mcwd_pkg::CNT_W'(mcwd_pkg::CHANNELS))
        else $error("registered count beyond channel count");

    a_reg_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.operation == mcwd_pkg::OP_REGISTER && o_res.accepted)
        |=> (r_total == $past(r_total) + 1'b1))
        else $error("accepted register did not advance the count");

    a_trip_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res.tripped) |=> (r_halted && r_alive == '0))
        else $error("trip did not halt and clear marks");

endmodule

/* hdl/multi_channel_watchdog.sv */
// Multi-channel watchdog top level: handshake and registered result stage.
//
// Each input transaction is one operation (register, kick, start, pause,
// stop, check tick) and produces exactly one result transaction. The
// operation is decoded and the channel state updated in the cycle the
// transaction is accepted; the result appears in the output register on the
// next cycle, and the block sustains one transaction per clock. Input ready
// is high whenever the output register is empty or is being emptied in the
// same cycle, so throughput drops only while the downstream side holds off
// ready. Up to mcwd_pkg::CHANNELS channels can be registered; a trip or a
// stop request leaves the block stopped until reset, and while stopped
// everything except request stop is refused.
module multi_channel_watchdog (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mcwd_pkg::t_item   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mcwd_pkg::t_result o_out_data
);

    logic              fire;
    mcwd_pkg::t_result res;
    mcwd_pkg::t_result r_out;
    logic              r_out_valid;

    // Output register may be refilled in the cycle it drains.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign fire       = i_in_valid && o_in_ready;

    mcwd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (i_in_data),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A trip always reports the stopped state.
    a_trip_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.tripped) |-> r_out.stopped_now)
        else $error("trip reported without stopped state");

    // Every accepted transaction yields a result on the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("accepted transaction produced no result");

    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!fire && r_out_valid && i_out_ready) |=> !r_out_valid)
        else $error("result repeated after delivery");

endmodule

/* bench/testbench.sv */
// Self-checking bench for the multi-channel watchdog: shadow model, random traffic, stalls.
module testbench;

    // Operation codes the block has no use for; it must refuse them.
    localparam logic [2:0] OP_UNUSED_LO = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;
    localparam int RANDOM_ITEMS = 510;
    localparam int TAIL_ITEMS   = 20;

    // Shadow of the watchdog state, plus the queue of results still owed.
    class watchdog_shadow;
        logic [mcwd_pkg::CHANNELS-1:0] alive;
        int                            n_registered;
        bit                            watching;
        bit                            halted;
        mcwd_pkg::t_result             owed_results[$];
        int                            errors;

        function new();
            alive        = '0;
            n_registered = 0;
            watching     = 1'b0;
            halted       = 1'b0;
            errors       = 0;
        endfunction

        // Registered channels that a tick would flag right now.
        function logic [mcwd_pkg::CHANNELS-1:0] missing();
            logic [mcwd_pkg::CHANNELS-1:0] enrolled;
            for (int ch = 0; ch < mcwd_pkg::CHANNELS; ch++) begin
                enrolled[ch] = (ch < n_registered);
            end
            return watching ? (enrolled & ~alive) : '0;
        endfunction

        function void take_operation(mcwd_pkg::t_item it);
            mcwd_pkg::t_result             res;
            logic [mcwd_pkg::CHANNELS-1:0] miss;
            res  = '0;
            miss = '0;
            if (it.operation == mcwd_pkg::OP_STOP) begin
                // stop is honoured even once halted
                halted       = 1'b1;
                res.accepted = 1'b1;
            end else if (!halted) begin
                case (it.operation)
                    mcwd_pkg::OP_REGISTER: begin
                        if (n_registered < mcwd_pkg::CHANNELS) begin
                            res.assigned_index  = 3'(n_registered);
                            alive[n_registered] = 1'b1;
                            n_registered++;
                            res.accepted        = 1'b1;
                        end
                    end
                    mcwd_pkg::OP_KICK: begin
                        if (int'(it.watch_index) < mcwd_pkg::CHANNELS) begin
                            alive[it.watch_index] = 1'b1;
                            res.accepted          = 1'b1;
                        end
                    end
                    mcwd_pkg::OP_START: begin
                        watching     = 1'b1;
                        res.accepted = 1'b1;
                    end
                    mcwd_pkg::OP_PAUSE: begin
                        watching     = 1'b0;
                        res.accepted = 1'b1;
                    end
                    mcwd_pkg::OP_TICK: begin
                        res.accepted = 1'b1;
                        miss         = missing();
                        alive        = '0;
                        if (miss != '0) begin
                            res.tripped = 1'b1;
                            halted      = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            res.missed_mask  = 8'(miss);
            res.stopped_now  = halted;
            res.watching_now = watching;
            owed_results.push_back(res);
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 100) $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare_result(input mcwd_pkg::t_result got);
            mcwd_pkg::t_result want;
            if (owed_results.size() == 0) begin
                report("result transaction with nothing outstanding");
                return;
            end
            want = owed_results.pop_front();
            if (got.assigned_index !== want.assigned_index)
                report($sformatf("assigned_index %0d, want %0d",
                                 got.assigned_index, want.assigned_index));
            if (got.accepted !== want.accepted)
                report($sformatf("accepted %b, want %b", got.accepted, want.accepted));
            if (got.tripped !== want.tripped)
                report($sformatf("tripped %b, want %b", got.tripped, want.tripped));
            if (got.missed_mask !== want.missed_mask)
                report($sformatf("missed_mask %b, want %b",
                                 got.missed_mask, want.missed_mask));
            if (got.stopped_now !== want.stopped_now)
                report($sformatf("stopped_now %b, want %b",
                                 got.stopped_now, want.stopped_now));
            if (got.watching_now !== want.watching_now)
                report($sformatf("watching_now %b, want %b",
                                 got.watching_now, want.watching_now));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    mcwd_pkg::t_item   i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    mcwd_pkg::t_result o_out_data;

    watchdog_shadow wd = new();
    bit no_idle = 1'b0;
    int counted = 0;

    multi_channel_watchdog u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Both handshakes are sampled here, input first, so the shadow is ahead of the result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) wd.take_operation(i_in_data);
            if (o_out_valid && i_out_ready) wd.compare_result(o_out_data);
        end
    end

    // Result side back-pressure: runs of ready broken by stalls.
    initial begin
        int run_left;
        int stall_left;
        run_left    = 0;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run_left == 0 && stall_left == 0) begin
                stall_left = pick_gap();
                run_left   = $urandom_range(1, 16);
            end
            if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
                run_left--;
            end
        end
    end

    // Entered and left at a falling edge; valid stays up after acceptance so the
    // next transaction can follow without a bubble.
    task automatic send_item(input mcwd_pkg::t_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = it;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic send_op(input logic [2:0] op, input int idx);
        mcwd_pkg::t_item it;
        it.operation   = op;
        it.watch_index = 3'(idx);
        send_item(it);
        if (op != OP_UNUSED_LO && op != OP_UNUSED_HI) counted++;
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (wd.owed_results.size() != 0) @(negedge i_clk);
    endtask

    // Random operation; unless a halt is allowed, a tick that would trip is
    // turned into a kick of one of the channels it would miss.
    task automatic random_item(input bit allow_halt);
        int                            r;
        int                            idx;
        logic [2:0]                    op;
        logic [mcwd_pkg::CHANNELS-1:0] miss;
        r   = $urandom_range(0, 99);
        idx = $urandom_range(0, 7);
        if (allow_halt)  op = 3'($urandom_range(0, 7));
        else if (r < 4)  op = mcwd_pkg::OP_REGISTER;
        else if (r < 62) op = mcwd_pkg::OP_KICK;
        else if (r < 67) op = mcwd_pkg::OP_START;
        else if (r < 70) op = mcwd_pkg::OP_PAUSE;
        else if (r < 74) op = r[0] ? OP_UNUSED_LO : OP_UNUSED_HI;
        else             op = mcwd_pkg::OP_TICK;
        miss = wd.missing();
        if (op == mcwd_pkg::OP_TICK && !allow_halt && miss != '0) begin
            op = mcwd_pkg::OP_KICK;
            do idx = $urandom_range(0, mcwd_pkg::CHANNELS - 1); while (!miss[idx]);
        end
        send_op(op, idx);
    endtask

    initial begin
        int  lost;
        bit  drained_once;
        drained_once = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty and paused ticks, unregistered kick, unused codes, filling up.
        send_op(mcwd_pkg::OP_TICK, 7);
        send_op(mcwd_pkg::OP_START, 0);
        send_op(mcwd_pkg::OP_TICK, 0);            // watching, nothing registered
        send_op(mcwd_pkg::OP_KICK, 7);            // slot not registered yet
        send_op(OP_UNUSED_LO, 0);
        send_op(OP_UNUSED_HI, 7);
        send_op(mcwd_pkg::OP_REGISTER, 5);
        send_op(mcwd_pkg::OP_REGISTER, 0);
        send_op(mcwd_pkg::OP_TICK, 2);            // both alive from registration
        send_op(mcwd_pkg::OP_PAUSE, 0);
        send_op(mcwd_pkg::OP_TICK, 0);            // misses ignored while paused
        send_op(mcwd_pkg::OP_START, 0);
        repeat (mcwd_pkg::CHANNELS - 2) send_op(mcwd_pkg::OP_REGISTER, 3);
        send_op(mcwd_pkg::OP_REGISTER, 1);        // full, refused
        send_op(mcwd_pkg::OP_KICK, 0);
        send_op(mcwd_pkg::OP_KICK, 1);
        send_op(mcwd_pkg::OP_TICK, 4);

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            no_idle = (counted >= 100 && counted < 160);
            if (counted >= 260 && !drained_once) begin
                wait_drained();
                drained_once = 1'b1;
            end
            random_item(1'b0);
        end
        no_idle = 1'b0;

        // Close out with a halt: either a stop request or a real trip.
        if ($urandom_range(0, 3) == 0) begin
            send_op(mcwd_pkg::OP_STOP, $urandom_range(0, 7));
        end else begin
            lost = $urandom_range(0, mcwd_pkg::CHANNELS - 1);
            send_op(mcwd_pkg::OP_START, 0);
            send_op(mcwd_pkg::OP_TICK, 0);
            for (int ch = 0; ch < mcwd_pkg::CHANNELS; ch++) begin
                if (ch != lost && $urandom_range(0, 1) == 1) send_op(mcwd_pkg::OP_KICK, ch);
            end
            send_op(mcwd_pkg::OP_TICK, 0);
        end
        repeat (TAIL_ITEMS) random_item(1'b1);

        wait_drained();
        repeat (4) @(negedge i_clk);
        if (wd.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* sim.f */
hdl/mcwd_pkg.sv
hdl/mcwd_core.sv
hdl/multi_channel_watchdog.sv
bench/testbench.sv
